FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, reset included.
`define FYDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define FYDS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: sv/fyds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fyds_pkg;

	localparam int DECK_SIZE = 52;
	localparam int SUIT_SIZE = 13;
	localparam int WORD_W    = 31;
	localparam int CARD_W    = 6;
	localparam int VALUE_W   = 4;
	localparam int SPAN_W    = CARD_W + 1;
	localparam int CNT_W     = $clog2(WORD_W);

	localparam logic [WORD_W-1:0]  RANDOM_MAX = 31'h7FFF_FFFF;
	localparam logic [CARD_W-1:0]  LAST_POS   = CARD_W'(DECK_SIZE - 1);
	localparam logic [CNT_W-1:0]   DIV_FIRST  = CNT_W'(WORD_W - 1);
	localparam logic [VALUE_W-1:0] ACE_VALUE  = 4'd11;
	localparam logic [VALUE_W-1:0] FACE_VALUE = 4'd10;

	typedef struct packed {
		logic load;       // capture word, clear remainders
		logic div_step;   // one restoring-division bit
		logic rd_swap;    // read entries at swap position and pick
		logic wr_pos;     // write pick entry into swap position
		logic wr_pick;    // write old swap entry into pick
		logic swap_next;  // step swap position down or restart it
		logic emit_rd;    // read deck entry for output
		logic emit_load;  // load output register
	} fyds_cmd_t;

	typedef struct packed {
		logic div_done;
		logic accept;
		logic pos_is_one;
		logic emit_last;
		logic out_free;
	} fyds_sts_t;

	function automatic logic [VALUE_W-1:0] card_value_of(input logic [CARD_W-1:0] id);
		logic [CARD_W-1:0] rank;
		begin
			if (id >= CARD_W'(4 * SUIT_SIZE)) begin
				rank = id - CARD_W'(4 * SUIT_SIZE);
			end else if (id >= CARD_W'(3 * SUIT_SIZE)) begin
				rank = id - CARD_W'(3 * SUIT_SIZE);
			end else if (id >= CARD_W'(2 * SUIT_SIZE)) begin
				rank = id - CARD_W'(2 * SUIT_SIZE);
			end else if (id >= CARD_W'(SUIT_SIZE)) begin
				rank = id - CARD_W'(SUIT_SIZE);
			end else begin
				rank = id;
			end
			if (rank == '0) begin
				return ACE_VALUE;
			end else if (rank <= CARD_W'(8)) begin
				return VALUE_W'(rank) + VALUE_W'(1);
			end else begin
				return FACE_VALUE;
			end
		end
	endfunction

endpackage
`default_nettype wire

FILE: sv/fyds_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fyds_word_if;
	logic                         valid;
	logic                         ready;
	logic [fyds_pkg::WORD_W-1:0]  random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

FILE: sv/fyds_card_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fyds_card_if;
	logic                          valid;
	logic                          ready;
	logic [fyds_pkg::CARD_W-1:0]   deck_position;
	logic [fyds_pkg::CARD_W-1:0]   card_id;
	logic [fyds_pkg::VALUE_W-1:0]  card_value;
	logic                          last_card;

	modport source (output valid, output deck_position, output card_id,
		output card_value, output last_card, input ready);
	modport sink   (input valid, input deck_position, input card_id,
		input card_value, input last_card, output ready);
endinterface
`default_nettype wire

FILE: sv/fyds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fyds_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire fyds_pkg::fyds_sts_t sts,
	output fyds_pkg::fyds_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_WR_POS,
		ST_WR_PICK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q, state_d;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// reads are harmless when the word is rejected
				cmd.rd_swap = 1'b1;
				state_d     = sts.accept ? ST_WR_POS : ST_IDLE;
			end
			ST_WR_POS: begin
				cmd.wr_pos = 1'b1;
				state_d    = ST_WR_PICK;
			end
			ST_WR_PICK: begin
				cmd.wr_pick   = 1'b1;
				cmd.swap_next = 1'b1;
				state_d       = sts.pos_is_one ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == ST_IDLE);
		end
	end

endmodule
`default_nettype wire

FILE: sv/fyds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fyds_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fyds_pkg::WORD_W-1:0] random_word,
	input  wire fyds_pkg::fyds_cmd_t         cmd,
	output fyds_pkg::fyds_sts_t              sts,
	fyds_card_if.source                      card
);

	localparam int CW = fyds_pkg::CARD_W;
	localparam int SW = fyds_pkg::SPAN_W;
	localparam int WW = fyds_pkg::WORD_W;
	localparam int NW = fyds_pkg::CNT_W;

	// deck store; entries never written read as their own index
	logic [CW-1:0]                  mem [fyds_pkg::DECK_SIZE];
	logic [fyds_pkg::DECK_SIZE-1:0] vld_q;

	logic [WW-1:0]               word_q;
	logic [CW-1:0]               rem_w_q, rem_m_q;
	logic [fyds_pkg::CNT_W-1:0]  div_cnt_q;
	logic [CW-1:0]               swap_q;
	logic [CW-1:0]               emit_q;

	logic [CW-1:0] rd_a_mem_q, rd_a_addr_q, rd_b_mem_q, rd_b_addr_q;
	logic          rd_a_vld_q, rd_b_vld_q;
	logic [CW-1:0] rd_a, rd_b;

	logic [SW-1:0] span, t_w, t_m;
	logic [CW-1:0] rem_w_d, rem_m_d;
	logic [WW-1:0] limit;
	logic [CW-1:0] pick;
	logic [CW-1:0] ra_addr, wa_addr, wa_data;
	logic          ra_en, we;

	logic                         out_valid_q;
	logic [CW-1:0]                out_pos_q, out_id_q;
	logic [fyds_pkg::VALUE_W-1:0] out_value_q;
	logic                         out_last_q;

	// restoring division of the word and of RANDOM_MAX by span, one bit a cycle
	assign span    = SW'(swap_q) + SW'(1);
	assign t_w     = {rem_w_q, word_q[div_cnt_q]};
	assign t_m     = {rem_m_q, fyds_pkg::RANDOM_MAX[div_cnt_q]};
	assign rem_w_d = (t_w >= span) ? CW'(t_w - span) : CW'(t_w);
	assign rem_m_d = (t_m >= span) ? CW'(t_m - span) : CW'(t_m);

	// cutoff = (RANDOM_MAX / span) * span = RANDOM_MAX - RANDOM_MAX mod span
	assign limit = fyds_pkg::RANDOM_MAX - WW'(rem_m_q);
	assign pick  = rem_w_q;

	assign sts.div_done   = (div_cnt_q == '0);
	assign sts.accept     = (word_q < limit);
	assign sts.pos_is_one = (swap_q == CW'(1));
	assign sts.emit_last  = (emit_q == fyds_pkg::LAST_POS);
	assign sts.out_free   = !out_valid_q || card.ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q  <= random_word;
			rem_w_q <= '0;
			rem_m_q <= '0;
		end else if (cmd.div_step) begin
			rem_w_q <= rem_w_d;
			rem_m_q <= rem_m_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= fyds_pkg::DIV_FIRST;
			swap_q    <= fyds_pkg::LAST_POS;
			emit_q    <= '0;
		end else begin
			if (cmd.load) begin
				div_cnt_q <= fyds_pkg::DIV_FIRST;
			end else if (cmd.div_step && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - NW'(1);
			end
			if (cmd.swap_next) begin
				swap_q <= sts.pos_is_one ? fyds_pkg::LAST_POS : swap_q - CW'(1);
			end
			if (cmd.emit_load) begin
				emit_q <= sts.emit_last ? '0 : emit_q + CW'(1);
			end
		end
	end

	// memory ports
	assign ra_en   = cmd.rd_swap || cmd.emit_rd;
	assign ra_addr = cmd.emit_rd ? emit_q : swap_q;
	assign we      = cmd.wr_pos || cmd.wr_pick;
	assign wa_addr = cmd.wr_pos ? swap_q : pick;
	assign wa_data = cmd.wr_pos ? rd_b : rd_a;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa_addr] <= wa_data;
		end
		if (ra_en) begin
			rd_a_mem_q  <= mem[ra_addr];
			rd_a_vld_q  <= vld_q[ra_addr];
			rd_a_addr_q <= ra_addr;
		end
		if (cmd.rd_swap) begin
			rd_b_mem_q  <= mem[pick];
			rd_b_vld_q  <= vld_q[pick];
			rd_b_addr_q <= pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa_addr] <= 1'b1;
		end
	end

	assign rd_a = rd_a_vld_q ? rd_a_mem_q : rd_a_addr_q;
	assign rd_b = rd_b_vld_q ? rd_b_mem_q : rd_b_addr_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (card.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_pos_q   <= emit_q;
			out_id_q    <= rd_a;
			out_value_q <= fyds_pkg::card_value_of(rd_a);
			out_last_q  <= sts.emit_last;
		end
	end

	assign card.valid         = out_valid_q;
	assign card.deck_position = out_pos_q;
	assign card.card_id       = out_id_q;
	assign card.card_value    = out_value_q;
	assign card.last_card     = out_last_q;

endmodule
`default_nettype wire

FILE: sv/fisher_yates_deck_shuffler.sv
// Fisher-Yates deck shuffler.
// rnd  : valid/ready sink of 31-bit random words, one word per transaction.
// card : valid/ready source of deck entries (position, card id, game value,
//        last mark), one entry per transaction.
// Each word is divided by span = i+1 with a bit-serial divider; a word at
// or above the rejection cutoff is dropped with no output, else entry i is
// swapped with entry (word mod span) and i steps down, or restarts at
// DECK_SIZE-1 after i = 1. rnd is not ready while a word is divided and
// checked and, if it is accepted, while the swap is written. The swap that
// ends a shuffle is followed by the whole deck, entry by entry, while card
// is ready; when the receiver stalls the entry waits in the output register
// and the deck read-out waits with it. After the last entry is loaded, rnd
// is ready again even while that entry is still waiting to be taken.
// Reset puts the deck in identity order, i at DECK_SIZE-1 and drops any
// pending output. The deck is not restored between shuffles.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fisher_yates_deck_shuffler (
	input wire logic clk,
	input wire logic arst_n,
	fyds_word_if.sink   rnd,
	fyds_card_if.source card
);

	fyds_pkg::fyds_cmd_t cmd;
	fyds_pkg::fyds_sts_t sts;
	logic                in_ready;

	assign rnd.ready = in_ready;

	fyds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rnd.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fyds_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.random_word (rnd.random_word),
		.cmd         (cmd),
		.sts         (sts),
		.card        (card)
	);

	// a new deck may start loading once the last entry is in the output register, before it is taken
	`FYDS_ASSERT_ALWAYS(a_no_input_during_emit, clk, (cmd.emit_rd || cmd.emit_load) |-> !rnd.ready, "input ready while deck is read out")
	`FYDS_ASSERT_ALWAYS(a_load_into_free_reg, clk, cmd.emit_load |-> sts.out_free, "output register overwritten")
	`FYDS_ASSERT_RST(a_busy_after_accept, clk, arst_n, (rnd.valid && rnd.ready) |=> !rnd.ready, "second word taken while dividing")
	`FYDS_ASSERT_RST(a_idle_after_last, clk, arst_n, (card.valid && card.ready && card.last_card) |=> (!card.valid || card.deck_position == '0), "output after final entry of deck")

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import fyds_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 156;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [CARD_W-1:0]  deck_position;
		logic [CARD_W-1:0]  card_id;
		logic [VALUE_W-1:0] card_value;
		logic               last_card;
	} dealt_card_t;

	logic clk;
	logic arst_n;

	fyds_word_if rnd_if();
	fyds_card_if card_if();

	fisher_yates_deck_shuffler dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rnd   (rnd_if),
		.card  (card_if)
	);

	// Shadow deck and swap position, updated on every accepted word.
	logic [CARD_W-1:0] deck_model [DECK_SIZE];
	logic [CARD_W-1:0] top_slot;
	dealt_card_t       dealt_q[$];

	int mismatches  = 0;
	int cycle_count = 0;
	int burst_left  = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned active_slot();
		int unsigned pos;
		pos = top_slot;
		if (pos < 1 || pos >= DECK_SIZE)
			pos = DECK_SIZE - 1;
		return pos;
	endfunction

	function automatic int unsigned cutoff_for(input int unsigned span);
		return (int'(RANDOM_MAX) / span) * span;
	endfunction

	function automatic bit word_rejected(input logic [WORD_W-1:0] w);
		return int'(w) >= cutoff_for(active_slot() + 1);
	endfunction

	function automatic logic [VALUE_W-1:0] game_value(input logic [CARD_W-1:0] id);
		int unsigned rank;
		rank = id % SUIT_SIZE;
		if (rank == 0)
			return ACE_VALUE;
		if (rank <= 8)
			return VALUE_W'(rank + 1);
		return FACE_VALUE;
	endfunction

	function automatic void shuffle_with_word(input logic [WORD_W-1:0] w);
		int unsigned       pos;
		int unsigned       pick;
		logic [CARD_W-1:0] held;
		dealt_card_t       c;
		pos = active_slot();
		if (word_rejected(w))
			return;
		pick = int'(w) % (pos + 1);
		held = deck_model[pos];
		deck_model[pos] = deck_model[pick];
		deck_model[pick] = held;
		if (pos > 1) begin
			top_slot = CARD_W'(pos - 1);
			return;
		end
		for (int k = 0; k < DECK_SIZE; k++) begin
			c.deck_position = CARD_W'(k);
			c.card_id       = deck_model[k];
			c.card_value    = game_value(deck_model[k]);
			c.last_card     = (k == DECK_SIZE - 1);
			dealt_q.push_back(c);
		end
		top_slot = LAST_POS;
	endfunction

	// Sender works in bursts; valid stays high across back-to-back words.
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap > 0) begin
				@(negedge clk);
				rnd_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		rnd_if.valid       <= 1'b1;
		rnd_if.random_word <= w;
		do @(posedge clk); while (!rnd_if.ready);
		shuffle_with_word(w);
	endtask

	// Receiver stall pattern: runs of always-ready, coin-flip and mostly-stalled.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		card_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 80);
			end
			left--;
			case (mode)
				0: begin
					card_if.ready <= 1'b1;
				end
				1: begin
					card_if.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					card_if.ready <= ($urandom_range(0, 7) == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		dealt_card_t want;
		dealt_card_t got;
		if (arst_n && card_if.valid && card_if.ready) begin
			got.deck_position = card_if.deck_position;
			got.card_id       = card_if.card_id;
			got.card_value    = card_if.card_value;
			got.last_card     = card_if.last_card;
			if (dealt_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected card transaction: pos %0d id %0d value %0d last %0b",
						got.deck_position, got.card_id, got.card_value, got.last_card);
				mismatches++;
			end else begin
				want = dealt_q.pop_front();
				if (got.deck_position !== want.deck_position || got.card_id !== want.card_id ||
					got.card_value !== want.card_value || got.last_card !== want.last_card) begin
					if (mismatches < 10)
						$display("card mismatch: want pos %0d id %0d value %0d last %0b, got pos %0d id %0d value %0d last %0b",
							want.deck_position, want.card_id, want.card_value, want.last_card,
							got.deck_position, got.card_id, got.card_value, got.last_card);
					mismatches++;
				end
			end
		end
	end

	// Boundary words around the rejection cutoff, self-swap, pick of slot zero.
	task automatic test_edge_words();
		int unsigned span;
		send_word('0);
		send_word(RANDOM_MAX);
		span = active_slot() + 1;
		send_word(WORD_W'(cutoff_for(span) - 1));
		span = active_slot() + 1;
		send_word(WORD_W'(cutoff_for(span)));
		send_word(RANDOM_MAX - 1);
		send_word(WORD_W'(active_slot()));
		send_word(WORD_W'(active_slot() + 1));
		send_word(31'h2AAA_AAAA);
		send_word(31'h5555_5555);
		send_word(31'h4000_0000);
		send_word(31'h0000_0001);
		for (int k = 0; k < 6; k++) begin
			span = active_slot() + 1;
			send_word(WORD_W'(cutoff_for(span) + $urandom_range(0, 1)));
			send_word(WORD_W'($urandom_range(0, span - 1)));
		end
	endtask

	// Mostly full-range words; some near the top to hit rejection, some tiny.
	task automatic test_random_shuffles();
		int               sent;
		int               pick_kind;
		logic [WORD_W-1:0] w;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			pick_kind = $urandom_range(0, 19);
			if (pick_kind < 14)
				w = WORD_W'($urandom());
			else if (pick_kind < 17)
				w = RANDOM_MAX - WORD_W'($urandom_range(0, 63));
			else
				w = WORD_W'($urandom_range(0, 2 * (active_slot() + 1)));
			sent++;
			send_word(w);
		end
	endtask

	initial begin
		for (int k = 0; k < DECK_SIZE; k++)
			deck_model[k] = CARD_W'(k);
		top_slot = LAST_POS;
		arst_n = 1'b0;
		rnd_if.valid = 1'b0;
		rnd_if.random_word = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_edge_words();
		test_random_shuffles();

		@(negedge clk);
		rnd_if.valid <= 1'b0;
		while (dealt_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && dealt_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
